// ===== hdl/aho_pkg.sv =====
package aho_pkg;

  // Input mode codes
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_BUILD = 2'd2;
  localparam logic [1:0] MODE_SCAN  = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_FULL       = 2'd1;
  localparam logic [1:0] STAT_TOO_LONG   = 2'd2;
  localparam logic [1:0] STAT_LOAD_BUILT = 2'd3;

  // Most matches reported for one scanned byte
  localparam int RESULT_CAP = 32;

  typedef enum logic [4:0] {
    S_RST_CLR, S_CLR, S_IDLE, S_LD_CHK, S_LD_WR, S_BLD_START, S_BR_RD, S_BR_WR,
    S_BP, S_BP_RD, S_BP_FAIL, S_BC_RD, S_BC_TAG, S_BC_WR, S_SC_RD, S_SC_TAG,
    S_SC_FIRST, S_SC_CHAIN, S_SC_EMIT, S_RESP
  } ctl_state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_CLR_STEP, OP_LD_CHK, OP_LD_WR, OP_BLD_START, OP_BR_RD,
    OP_BR_WR, OP_BP_RD, OP_BP_FAIL, OP_BC_RD, OP_BC_TAG, OP_BC_WR, OP_BUILT,
    OP_SC_RD, OP_SC_TAG, OP_SC_FIRST, OP_SC_CHAIN, OP_SC_EMIT, OP_RESP
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic built;
    logic ld_go;
    logic col_last;
    logic q_empty;
    logic chain_more;
  } dp_status_t;

endpackage

// ===== hdl/aho_ctrl.sv =====
module aho_ctrl import aho_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] mode_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy
);

  ctl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_RST_CLR:   if (status_i.sweep_last) state_d = S_IDLE;
      S_CLR:       if (status_i.sweep_last) state_d = S_RESP;
      S_IDLE: begin
        if (start) begin
          case (mode_i)
            MODE_CLEAR: state_d = S_CLR;
            MODE_LOAD:  state_d = S_LD_CHK;
            MODE_BUILD: state_d = S_BLD_START;
            default:    state_d = S_SC_RD;
          endcase
        end
      end
      S_LD_CHK:    state_d = status_i.ld_go ? S_LD_WR : S_RESP;
      S_LD_WR:     state_d = S_RESP;
      S_BLD_START: state_d = status_i.built ? S_RESP : S_BR_RD;
      S_BR_RD:     state_d = S_BR_WR;
      S_BR_WR:     state_d = status_i.col_last ? S_BP : S_BR_RD;
      S_BP:        state_d = status_i.q_empty ? S_RESP : S_BP_RD;
      S_BP_RD:     state_d = S_BP_FAIL;
      S_BP_FAIL:   state_d = S_BC_RD;
      S_BC_RD:     state_d = S_BC_TAG;
      S_BC_TAG:    state_d = S_BC_WR;
      S_BC_WR:     state_d = status_i.col_last ? S_BP : S_BC_RD;
      S_SC_RD:     state_d = S_SC_TAG;
      S_SC_TAG:    state_d = S_SC_FIRST;
      S_SC_FIRST:  state_d = status_i.chain_more ? S_SC_CHAIN : S_IDLE;
      S_SC_CHAIN:  state_d = S_SC_EMIT;
      S_SC_EMIT:   state_d = status_i.chain_more ? S_SC_CHAIN : S_IDLE;
      S_RESP:      state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o.op = OP_NONE;
    case (state_q)
      S_RST_CLR, S_CLR: cmd_o.op = OP_CLR_STEP;
      S_IDLE:      cmd_o.op = start ? OP_ACCEPT : OP_NONE;
      S_LD_CHK:    cmd_o.op = OP_LD_CHK;
      S_LD_WR:     cmd_o.op = OP_LD_WR;
      S_BLD_START: cmd_o.op = OP_BLD_START;
      S_BR_RD:     cmd_o.op = OP_BR_RD;
      S_BR_WR:     cmd_o.op = OP_BR_WR;
      S_BP:        cmd_o.op = status_i.q_empty ? OP_BUILT : OP_NONE;
      S_BP_RD:     cmd_o.op = OP_BP_RD;
      S_BP_FAIL:   cmd_o.op = OP_BP_FAIL;
      S_BC_RD:     cmd_o.op = OP_BC_RD;
      S_BC_TAG:    cmd_o.op = OP_BC_TAG;
      S_BC_WR:     cmd_o.op = OP_BC_WR;
      S_SC_RD:     cmd_o.op = OP_SC_RD;
      S_SC_TAG:    cmd_o.op = OP_SC_TAG;
      S_SC_FIRST:  cmd_o.op = OP_SC_FIRST;
      S_SC_CHAIN:  cmd_o.op = OP_SC_CHAIN;
      S_SC_EMIT:   cmd_o.op = OP_SC_EMIT;
      S_RESP:      cmd_o.op = OP_RESP;
      default:     cmd_o.op = OP_NONE;
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ===== hdl/aho_datapath.sv =====
module aho_datapath import aho_pkg::*; #(
  parameter int MAX_STATES      = 256,
  parameter int ALPHABET_SIZE   = 256,
  parameter int MAX_PATTERN_LEN = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  data_byte_i,
  input  logic        pattern_end_i,
  input  logic [7:0]  pattern_id_i,
  input  dp_cmd_t     cmd_i,
  output dp_status_t  status_o,
  output logic        valid_o,
  output logic        match_found_o,
  output logic [7:0]  match_pattern_o,
  output logic [31:0] match_position_o,
  output logic [1:0]  status_o_field,
  output logic        last_result_o
);

  localparam int SW  = $clog2(MAX_STATES);
  localparam int ACW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int GD  = MAX_STATES * ALPHABET_SIZE;
  localparam int GAW = $clog2(GD);
  localparam int LW  = $clog2(MAX_PATTERN_LEN + 1);
  localparam int QW  = SW + 1;

  // Memories
  logic [SW-1:0] goto_mem [GD];
  logic [SW-1:0] fail_mem [MAX_STATES];
  logic [8:0]    tag_mem  [MAX_STATES];
  logic [SW-1:0] dict_mem [MAX_STATES];
  logic [SW-1:0] q_mem    [MAX_STATES];

  // Latched transaction and control state
  logic [7:0]     byte_q;
  logic           fin_q;
  logic [7:0]     id_q;
  logic           built_q;
  logic [SW-1:0]  next_free_q, cursor_q, scan_q, cur_q;
  logic [LW-1:0]  len_q;
  logic [31:0]    pos_q, spos_q;
  logic [ACW-1:0] col_q;
  logic [GAW-1:0] sweep_q;
  logic [QW-1:0]  front_q, rear_q;
  logic [5:0]     nres_q;
  logic [1:0]     stat_q;

  // Registered read data
  logic [SW-1:0] rd0_q, rd1_q, fail_rd_q, dict_rd_q, q_rd_q;
  logic [8:0]    tag_rd_q;

  // Result registers
  logic          valid_q, valid_d, found_q, last_q;
  logic [7:0]    pat_q;
  logic [31:0]   rpos_q;
  logic [1:0]    rstat_q;

  // Memory port controls
  logic           gre0, gre1, gwe, fre, fwe, tre, twe, dre, dwe, qre, qwe;
  logic [GAW-1:0] ga0, ga1, gwa;
  logic [SW-1:0]  gwd, fra, fwa, fwd, tra, twa, dra, dwa, dwd, qra, qwa, qwd;
  logic [8:0]     twd;

  logic [ACW-1:0] bcol;
  logic           full, ld_ok, more_emit;
  logic [SW-1:0]  ld_nxt;
  logic [8:0]     tag_m1;

  function automatic logic [GAW-1:0] gidx(input logic [SW-1:0] s, input logic [ACW-1:0] c);
    gidx = GAW'(s) * GAW'(ALPHABET_SIZE) + GAW'(c);
  endfunction

  // Byte to column: restoring reduction modulo the alphabet size
  always_comb begin
    logic [15:0] v;
    v = {8'd0, byte_q};
    for (int k = 7; k >= 0; k--) begin
      if (v >= (16'(ALPHABET_SIZE) << k)) v = v - (16'(ALPHABET_SIZE) << k);
    end
    bcol = v[ACW-1:0];
  end

  assign full      = (next_free_q == SW'(MAX_STATES - 1));
  assign ld_ok     = !((rd0_q == '0) && full);
  assign ld_nxt    = (rd0_q == '0) ? next_free_q + SW'(1) : rd0_q;
  assign tag_m1    = tag_rd_q - 9'd1;
  assign more_emit = (dict_rd_q != '0) && (nres_q != 6'(RESULT_CAP - 1));

  // Status to the controller
  always_comb begin
    status_o.sweep_last = (sweep_q == GAW'(GD - 1));
    status_o.built      = built_q;
    status_o.ld_go      = !built_q && (len_q < LW'(MAX_PATTERN_LEN));
    status_o.col_last   = (col_q == ACW'(ALPHABET_SIZE - 1));
    status_o.q_empty    = (front_q == rear_q);
    if (cmd_i.op == OP_SC_FIRST && tag_rd_q == '0) begin
      status_o.chain_more = (dict_rd_q != '0);
    end else begin
      status_o.chain_more = more_emit;
    end
  end

  // Memory port selection
  always_comb begin
    gre0 = 1'b0; gre1 = 1'b0; gwe = 1'b0; fre = 1'b0; fwe = 1'b0;
    tre = 1'b0; twe = 1'b0; dre = 1'b0; dwe = 1'b0; qre = 1'b0; qwe = 1'b0;
    ga0 = '0; ga1 = '0; gwa = '0; gwd = '0;
    fra = '0; fwa = '0; fwd = '0; tra = '0; twa = '0; twd = '0;
    dra = '0; dwa = '0; dwd = '0; qra = '0; qwa = '0; qwd = '0;
    case (cmd_i.op)
      OP_CLR_STEP: begin
        gwe = 1'b1;
        gwa = sweep_q;
        if (sweep_q < GAW'(MAX_STATES)) begin
          fwe = 1'b1; twe = 1'b1; dwe = 1'b1;
          fwa = sweep_q[SW-1:0]; twa = sweep_q[SW-1:0]; dwa = sweep_q[SW-1:0];
        end
      end
      OP_LD_CHK: begin
        gre0 = status_o.ld_go;
        ga0  = gidx(cursor_q, bcol);
      end
      OP_LD_WR: begin
        gwa = gidx(cursor_q, bcol);
        gwd = ld_nxt;
        gwe = (rd0_q == '0) && !full;
        twe = fin_q && ld_ok;
        twa = ld_nxt;
        twd = {1'b0, id_q} + 9'd1;
      end
      OP_BR_RD: begin
        gre0 = 1'b1;
        ga0  = gidx('0, col_q);
      end
      OP_BR_WR: begin
        qwe = (rd0_q != '0);
        qwa = rear_q[SW-1:0];
        qwd = rd0_q;
      end
      OP_BP_RD: begin
        qre = 1'b1;
        qra = front_q[SW-1:0];
      end
      OP_BP_FAIL: begin
        fre = 1'b1;
        fra = q_rd_q;
      end
      OP_BC_RD: begin
        gre0 = 1'b1;
        ga0  = gidx(q_rd_q, col_q);
        gre1 = 1'b1;
        ga1  = gidx(fail_rd_q, col_q);
      end
      OP_BC_TAG: begin
        tre = 1'b1; tra = rd1_q;
        dre = 1'b1; dra = rd1_q;
      end
      OP_BC_WR: begin
        if (rd0_q == '0) begin
          // missing edge: copy the failure state's transition
          gwe = 1'b1;
          gwa = gidx(q_rd_q, col_q);
          gwd = rd1_q;
        end else begin
          qwe = 1'b1; qwa = rear_q[SW-1:0]; qwd = rd0_q;
          fwe = 1'b1; fwa = rd0_q; fwd = rd1_q;
          dwe = 1'b1; dwa = rd0_q;
          dwd = (tag_rd_q != '0) ? rd1_q : dict_rd_q;
        end
      end
      OP_SC_RD: begin
        gre0 = 1'b1;
        ga0  = gidx(scan_q, bcol);
      end
      OP_SC_TAG: begin
        tre = 1'b1; tra = rd0_q;
        dre = 1'b1; dra = rd0_q;
      end
      OP_SC_CHAIN: begin
        tre = 1'b1; tra = cur_q;
        dre = 1'b1; dra = cur_q;
      end
      default: ;
    endcase
  end

  // Memory access
  always_ff @(posedge clk_i) begin
    if (gwe) goto_mem[gwa] <= gwd;
    if (gre0) rd0_q <= goto_mem[ga0];
    if (gre1) rd1_q <= goto_mem[ga1];
    if (fwe) fail_mem[fwa] <= fwd;
    if (fre) fail_rd_q <= fail_mem[fra];
    if (twe) tag_mem[twa] <= twd;
    if (tre) tag_rd_q <= tag_mem[tra];
    if (dwe) dict_mem[dwa] <= dwd;
    if (dre) dict_rd_q <= dict_mem[dra];
    if (qwe) q_mem[qwa] <= qwd;
    if (qre) q_rd_q <= q_mem[qra];
  end

  // Transaction latch and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_ACCEPT) begin
      byte_q <= data_byte_i;
      fin_q  <= pattern_end_i;
      id_q   <= pattern_id_i;
    end
    if (cmd_i.op == OP_SC_TAG) spos_q <= pos_q;
    case (cmd_i.op)
      OP_RESP: begin
        found_q <= 1'b0; pat_q <= '0; rpos_q <= '0; rstat_q <= stat_q; last_q <= 1'b1;
      end
      OP_SC_FIRST, OP_SC_EMIT: begin
        rpos_q  <= spos_q;
        rstat_q <= STAT_OK;
        if (cmd_i.op == OP_SC_FIRST && tag_rd_q == '0) begin
          found_q <= 1'b0; pat_q <= '0; last_q <= 1'b1;
        end else begin
          found_q <= 1'b1; pat_q <= tag_m1[7:0]; last_q <= !more_emit;
        end
      end
      default: ;
    endcase
  end

  // Result strobe
  always_comb begin
    case (cmd_i.op)
      OP_RESP, OP_SC_EMIT: valid_d = 1'b1;
      OP_SC_FIRST:         valid_d = (tag_rd_q != '0) || (dict_rd_q == '0);
      default:             valid_d = 1'b0;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      built_q <= 1'b0; next_free_q <= '0; cursor_q <= '0; len_q <= '0;
      scan_q <= '0; pos_q <= '0; col_q <= '0; sweep_q <= '0;
      front_q <= '0; rear_q <= '0; cur_q <= '0; nres_q <= '0;
      stat_q <= STAT_OK; valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      case (cmd_i.op)
        OP_ACCEPT: begin
          stat_q <= STAT_OK;
          if (mode_i == MODE_CLEAR) begin
            built_q <= 1'b0; next_free_q <= '0; cursor_q <= '0; len_q <= '0;
            scan_q <= '0; pos_q <= '0; sweep_q <= '0;
          end
        end
        OP_CLR_STEP: sweep_q <= status_o.sweep_last ? '0 : sweep_q + GAW'(1);
        OP_LD_CHK: begin
          if (built_q) begin
            stat_q <= STAT_LOAD_BUILT;
          end else if (!status_o.ld_go) begin
            stat_q <= STAT_TOO_LONG;
            if (fin_q) begin
              cursor_q <= '0; len_q <= '0;
            end
          end
        end
        OP_LD_WR: begin
          if (!ld_ok) begin
            stat_q <= STAT_FULL;
            len_q  <= fin_q ? '0 : LW'(MAX_PATTERN_LEN);
            if (fin_q) cursor_q <= '0;
          end else begin
            if (rd0_q == '0) next_free_q <= next_free_q + SW'(1);
            cursor_q <= fin_q ? '0 : ld_nxt;
            len_q    <= fin_q ? '0 : len_q + LW'(1);
          end
        end
        OP_BLD_START: begin
          col_q <= '0; front_q <= '0; rear_q <= '0;
        end
        OP_BR_WR, OP_BC_WR: begin
          if (rd0_q != '0) rear_q <= rear_q + QW'(1);
          col_q <= status_o.col_last ? '0 : col_q + ACW'(1);
        end
        OP_BP_RD:   front_q <= front_q + QW'(1);
        OP_BP_FAIL: col_q <= '0;
        OP_BUILT:   built_q <= 1'b1;
        OP_SC_TAG: begin
          scan_q <= rd0_q;
          pos_q  <= pos_q + 32'd1;
          nres_q <= '0;
        end
        OP_SC_FIRST: begin
          cur_q <= dict_rd_q;
          if (tag_rd_q != '0) nres_q <= 6'd1;
        end
        OP_SC_EMIT: begin
          nres_q  <= nres_q + 6'd1;
          cur_q   <= dict_rd_q;
        end
        default: ;
      endcase
    end
  end

  assign valid_o          = valid_q;
  assign match_found_o    = found_q;
  assign match_pattern_o  = pat_q;
  assign match_position_o = rpos_q;
  assign status_o_field   = rstat_q;
  assign last_result_o    = last_q;

endmodule

// ===== hdl/aho_corasick_matcher_core.sv =====
// Multi-pattern byte matcher. Pulse start while busy is low to issue a
// transaction (clear, load a pattern byte, build links, scan a text byte); each
// result appears on the match ports for one cycle with valid_o high, and the
// receiver must take it then since it cannot stall. Clear sweeps the goto table
// one table entry a cycle, also clearing the fail, tag and dictionary tables,
// and the same sweep runs after reset with busy high. Build walks the trie
// breadth-first through a queue. A scan byte reads the goto table, then the tag
// and dictionary link, gives its first result, and then walks the dictionary
// chain for each further match.
module aho_corasick_matcher_core import aho_pkg::*; #(
  parameter int MAX_STATES      = 256,
  parameter int ALPHABET_SIZE   = 256,
  parameter int MAX_PATTERN_LEN = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  data_byte_i,
  input  logic        pattern_end_i,
  input  logic [7:0]  pattern_id_i,
  output logic        valid_o,
  output logic        match_found_o,
  output logic [7:0]  match_pattern_o,
  output logic [31:0] match_position_o,
  output logic [1:0]  status_o,
  output logic        last_result_o
);

  dp_cmd_t    cmd;
  dp_status_t dp_status;

  // Sequencer
  aho_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .mode_i   (mode_i),
    .status_i (dp_status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // Tables and registers
  aho_datapath #(
    .MAX_STATES      (MAX_STATES),
    .ALPHABET_SIZE   (ALPHABET_SIZE),
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .mode_i           (mode_i),
    .data_byte_i      (data_byte_i),
    .pattern_end_i    (pattern_end_i),
    .pattern_id_i     (pattern_id_i),
    .cmd_i            (cmd),
    .status_o         (dp_status),
    .valid_o          (valid_o),
    .match_found_o    (match_found_o),
    .match_pattern_o  (match_pattern_o),
    .match_position_o (match_position_o),
    .status_o_field   (status_o),
    .last_result_o    (last_result_o)
  );

  // An accepted transaction raises busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // No further result after the last one of a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_result_o) |=> !valid_o)
    else $error("result strobe after last result");

  // More results pending keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_result_o) |-> busy)
    else $error("idle with results pending");

  // A match never carries an error status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && match_found_o) |-> (status_o == STAT_OK))
    else $error("match reported with error status");

endmodule
